// ===== rtl/core/cls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_pkg: shared definitions for the Cramer linear system solver
// Types, codes, sizes and the permutation table used by the solver core.
// ----------------------------------------------------------------------------
package cls_pkg;

   localparam int MAX_SIZE   = 4;
   localparam int STORE_COLS = MAX_SIZE + 1;
   localparam int FRAC_BITS  = 16;

   // Signed accumulator for an exact 4x4 determinant of 32-bit entries.
   localparam int ACC_W = 132;
   localparam int MAG_W = ACC_W + FRAC_BITS;
   localparam int DIV_W = ACC_W + 32;

   localparam int PERM_COUNT = 24;

   localparam logic [1:0] KIND_DETERMINANT = 2'd0;
   localparam logic [1:0] KIND_SOLUTION    = 2'd1;
   localparam logic [1:0] KIND_NOT_SQUARE  = 2'd2;

   localparam logic [1:0] CSR_EQUATION_COUNT     = 2'd0;
   localparam logic [1:0] CSR_VARIABLE_COUNT     = 2'd1;
   localparam logic [1:0] CSR_SINGULAR_THRESHOLD = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL,
      ST_ACC,
      ST_DET_DONE,
      ST_REPORT,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Each entry packs the column of row k at bits [2k+1:2k].
   localparam logic [7:0] PERM_TABLE [PERM_COUNT] = '{
      {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
      {2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
      {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
      {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
      {2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
      {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
      {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
      {2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
      {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
      {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3},
      {2'd2, 2'd0, 2'd1, 2'd3}, {2'd0, 2'd2, 2'd1, 2'd3},
      {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
   };

   // Bit p is set when permutation p is odd.
   localparam logic [PERM_COUNT-1:0] PERM_ODD = 24'b0110_0110_0110_0110_0110_0110;

   typedef struct packed {
      logic             start;
      logic             neg;
   } div_ctrl_type;

   function automatic logic [31:0] saturate(input logic high, input logic [31:0] lo,
                                            input logic neg);
      logic [31:0] r;
      if (neg) begin
         r = (high || lo > 32'h8000_0000) ? 32'h8000_0000 : (~lo + 32'd1);
      end else begin
         r = (high || lo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : lo;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/cls_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_req_if: entry load channel
// Carries one system entry per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cls_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         row;
   logic [2:0]         column;
   logic signed [31:0] entry_value;
   logic               last_entry;

   modport source (output valid, row, column, entry_value, last_entry, input ready);
   modport sink   (input valid, row, column, entry_value, last_entry, output ready);
endinterface

// ===== rtl/core/cls_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_rsp_if: result channel
// Carries one determinant, solution or not-square result per transfer.
// ----------------------------------------------------------------------------
interface cls_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [1:0]         var_index;
   logic signed [31:0] result_value;
   logic               last_result;

   modport source (output valid, kind, var_index, result_value, last_result, input ready);
   modport sink   (input valid, kind, var_index, result_value, last_result, output ready);
endinterface

// ===== rtl/core/cls_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_divider: restoring divider for Cramer ratios
// Produces a 33-bit quotient one bit per cycle and saturates it to 32 bits.
// ----------------------------------------------------------------------------
module cls_divider
   import cls_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctrl_type       ctrl,
   input  logic [DIV_W-1:0]   numerator,
   input  logic [ACC_W-1:0]   denominator,
   output logic               done,
   output logic [31:0]        quotient
);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [32:0]      q_ff, q_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = numerator;
         dvs_in  = {denominator, 32'd0};
         q_in    = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
         neg_in  = ctrl.neg;
      end else if (busy_ff) begin
         // Any quotient at or above 2^32 saturates, so bit 32 is handled like the rest.
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            q_in   = {q_ff[31:0], 1'b1};
         end else begin
            q_in   = {q_ff[31:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = saturate(q_ff[32], q_ff[31:0], neg_ff);

endmodule

// ===== rtl/core/cramer_linear_system_solver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cramer_linear_system_solver_unit: Cramer's rule solver, up to 4x4, Q16.16
// Loads entries into a register store, then computes exact determinants by
// summing 24 permutation products on one shared 32x32 multiplier and
// divides each Cramer determinant by the system determinant.
// ----------------------------------------------------------------------------
// Entries load one per cycle while the unit is idle, and a non-last entry keeps it idle.
// Each of the 24 terms of a determinant is fetched, multiplied one limb product per cycle and accumulated.
// The determinant result follows the last entry once its terms are summed; each
// solution adds a further determinant and a division by the system determinant.
// After the last entry, a not-square result passes through the emit state into the output register.
// Synchronous reset clears the store valid bits, the configuration registers, the state and the output valid.
module cramer_linear_system_solver_unit
   import cls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cls_req_if.sink     req_bus,
   cls_rsp_if.source   rsp_bus,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   logic [2:0]  eq_count_ff;
   logic [2:0]  var_count_ff;
   logic [15:0] threshold_ff;

   logic [31:0]                      store_ff [MAX_SIZE][STORE_COLS];
   logic [MAX_SIZE-1:0][STORE_COLS-1:0] valid_ff;

   state_type          state_ff, state_in;
   logic               pass_ff, pass_in;
   logic [2:0]         var_ff, var_in;
   logic [4:0]         perm_ff, perm_in;
   logic [1:0]         k_ff, k_in;
   logic [1:0]         limb_ff, limb_in;
   logic [3:0][31:0]   prod_ff, prod_in;
   logic [31:0]        carry_ff, carry_in;
   logic               psign_ff, psign_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   det_ff, det_in;
   logic [ACC_W-1:0]   dmag_ff, dmag_in;
   logic               dneg_ff, dneg_in;
   logic [1:0]         emit_kind_ff, emit_kind_in;
   logic [31:0]        emit_val_ff, emit_val_in;
   logic               emit_last_ff, emit_last_in;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_kind_ff;
   logic [1:0]         rsp_var_ff;
   logic [31:0]        rsp_val_ff;
   logic               rsp_last_ff;

   logic               req_fire;
   logic               store_we;
   logic               store_clear;
   logic               rsp_load;

   logic [1:0]         fetch_row;
   logic [1:0]         fetch_col;
   logic [2:0]         col_sel;
   logic               in_system;
   logic [31:0]        stored;
   logic [31:0]        entry;
   logic               e_neg;
   logic [31:0]        e_mag;
   logic [63:0]        mult;
   logic [63:0]        limb_sum;
   logic [ACC_W-1:0]   prod_wide;
   logic [ACC_W-1:0]   acc_abs;
   logic [MAG_W-1:0]   det_mag;
   logic               mag_small;
   logic               singular;

   div_ctrl_type       div_ctrl;
   logic               div_done;
   logic [31:0]        div_quotient;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign store_we = req_fire && (3'(req_bus.row) < 3'(MAX_SIZE))
                     && (req_bus.column <= 3'(MAX_SIZE));
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);
   assign store_clear = rsp_load && emit_last_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         eq_count_ff  <= 3'd0;
         var_count_ff <= 3'd0;
         threshold_ff <= 16'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EQUATION_COUNT:     eq_count_ff  <= csr_write_data[2:0];
            CSR_VARIABLE_COUNT:     var_count_ff <= csr_write_data[2:0];
            CSR_SINGULAR_THRESHOLD: threshold_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // System store; an entry without its valid bit reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (store_clear) begin
         valid_ff <= '0;
      end else if (store_we) begin
         valid_ff[req_bus.row][req_bus.column] <= 1'b1;
      end
      if (store_we) begin
         store_ff[req_bus.row][req_bus.column] <= req_bus.entry_value;
      end
   end

   // Outside the n x n system the matrix is padded with an identity, which
   // leaves the determinant unchanged and lets every pass run all 24 terms.
   always_comb begin
      fetch_row = (state_ff == ST_FETCH) ? 2'd0 : k_ff;
      fetch_col = PERM_TABLE[perm_ff][{fetch_row, 1'b0} +: 2];
      in_system = ({1'b0, fetch_row} < var_count_ff) && ({1'b0, fetch_col} < var_count_ff);
      col_sel   = (pass_ff && fetch_col == var_ff[1:0]) ? var_count_ff : {1'b0, fetch_col};
      stored    = valid_ff[fetch_row][col_sel] ? store_ff[fetch_row][col_sel] : 32'd0;
      if (in_system) begin
         entry = stored;
      end else begin
         entry = (fetch_row == fetch_col) ? 32'd1 : 32'd0;
      end
      e_neg = entry[31];
      e_mag = e_neg ? (~entry + 32'd1) : entry;
   end

   assign mult      = 64'(prod_ff[limb_ff]) * 64'(e_mag);
   assign limb_sum  = mult + 64'(carry_ff);
   assign prod_wide = ACC_W'(prod_ff);
   assign acc_abs   = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;

   always_comb begin
      case (var_count_ff)
         3'd0:    det_mag = MAG_W'(dmag_ff) << FRAC_BITS;
         3'd1:    det_mag = MAG_W'(dmag_ff);
         3'd2:    det_mag = MAG_W'(dmag_ff) >> FRAC_BITS;
         3'd3:    det_mag = MAG_W'(dmag_ff) >> (2 * FRAC_BITS);
         default: det_mag = MAG_W'(dmag_ff) >> (3 * FRAC_BITS);
      endcase
      mag_small = (det_mag[MAG_W-1:32] == '0);
      singular  = (det_ff == '0) || (mag_small && det_mag[31:0] < {16'd0, threshold_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pass_ff      <= pass_in;
      var_ff       <= var_in;
      perm_ff      <= perm_in;
      k_ff         <= k_in;
      limb_ff      <= limb_in;
      prod_ff      <= prod_in;
      carry_ff     <= carry_in;
      psign_ff     <= psign_in;
      acc_ff       <= acc_in;
      det_ff       <= det_in;
      dmag_ff      <= dmag_in;
      dneg_ff      <= dneg_in;
      emit_kind_ff <= emit_kind_in;
      emit_val_ff  <= emit_val_in;
      emit_last_ff <= emit_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      var_in       = var_ff;
      perm_in      = perm_ff;
      k_in         = k_ff;
      limb_in      = limb_ff;
      prod_in      = prod_ff;
      carry_in     = carry_ff;
      psign_in     = psign_ff;
      acc_in       = acc_ff;
      det_in       = det_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      emit_kind_in = emit_kind_ff;
      emit_val_in  = emit_val_ff;
      emit_last_in = emit_last_ff;
      div_ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_bus.last_entry) begin
               if (eq_count_ff != var_count_ff || var_count_ff > 3'(MAX_SIZE)) begin
                  emit_kind_in = KIND_NOT_SQUARE;
                  emit_val_in  = 32'd0;
                  emit_last_in = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  pass_in  = 1'b0;
                  var_in   = 3'd0;
                  perm_in  = 5'd0;
                  acc_in   = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            prod_in  = {32'd0, 32'd0, 32'd0, e_mag};
            psign_in = e_neg ^ PERM_ODD[perm_ff];
            k_in     = 2'd1;
            limb_in  = 2'd0;
            carry_in = 32'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // One limb of the running product times the next factor per cycle.
            prod_in[limb_ff] = limb_sum[31:0];
            carry_in         = limb_sum[63:32];
            limb_in          = limb_ff + 2'd1;
            if (limb_ff == 2'd0) begin
               psign_in = psign_ff ^ e_neg;
            end
            if (limb_ff == 2'd3) begin
               carry_in = 32'd0;
               k_in     = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_in = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            acc_in = psign_ff ? (acc_ff - prod_wide) : (acc_ff + prod_wide);
            if (perm_ff == 5'(PERM_COUNT - 1)) begin
               state_in = ST_DET_DONE;
            end else begin
               perm_in  = perm_ff + 5'd1;
               state_in = ST_FETCH;
            end
         end
         ST_DET_DONE: begin
            if (!pass_ff) begin
               det_in   = acc_ff;
               dmag_in  = acc_abs;
               dneg_in  = acc_ff[ACC_W-1];
               state_in = ST_REPORT;
            end else begin
               div_ctrl.start = 1'b1;
               div_ctrl.neg   = acc_ff[ACC_W-1] ^ dneg_ff;
               state_in       = ST_DIV;
            end
         end
         ST_REPORT: begin
            emit_kind_in = KIND_DETERMINANT;
            emit_val_in  = saturate(!mag_small, det_mag[31:0], dneg_ff);
            emit_last_in = singular || (var_count_ff == 3'd0);
            state_in     = ST_EMIT;
         end
         ST_DIV: begin
            if (div_done) begin
               emit_kind_in = KIND_SOLUTION;
               emit_val_in  = div_quotient;
               emit_last_in = (3'(var_ff + 3'd1) == var_count_ff);
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               if (emit_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  var_in   = pass_ff ? 3'(var_ff + 3'd1) : 3'd0;
                  pass_in  = 1'b1;
                  perm_in  = 5'd0;
                  acc_in   = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   cls_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (div_ctrl),
      .numerator   (DIV_W'(acc_abs) << FRAC_BITS),
      .denominator (dmag_ff),
      .done        (div_done),
      .quotient    (div_quotient)
   );

   // Output register; the next item loads when the register is empty or its result is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_kind_ff <= emit_kind_ff;
         rsp_var_ff  <= (emit_kind_ff == KIND_SOLUTION) ? var_ff[1:0] : 2'd0;
         rsp_val_ff  <= emit_val_ff;
         rsp_last_ff <= emit_last_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kind         = rsp_kind_ff;
   assign rsp_bus.var_index    = rsp_var_ff;
   assign rsp_bus.result_value = rsp_val_ff;
   assign rsp_bus.last_result  = rsp_last_ff;

   a_solve_blocks_load: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.last_entry) |=> !req_bus.ready)
      else $error("entry accepted right after the last entry");

   a_store_cleared: assert property (@(posedge clock) disable iff (reset)
      store_clear |=> (valid_ff == '0))
      else $error("store not cleared after the final result");

   a_perm_range: assert property (@(posedge clock) disable iff (reset)
      perm_ff < 5'(PERM_COUNT) || state_ff == ST_IDLE)
      else $error("permutation index out of range");

   a_div_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the wait state");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Cramer linear system solver unit
// Loads systems of Q16.16 entries under several size and threshold settings,
// computes the determinant and the solutions with exact wide arithmetic, and
// compares every result transfer field by field, in order, with the
// prediction. Both channels idle at random; the result side is also held off
// for a long stretch so that the entry channel backs up.
// ----------------------------------------------------------------------------
module tb_top;
   import cls_pkg::*;

   typedef struct {
      logic [1:0]  row;
      logic [2:0]  column;
      logic [31:0] value;
      logic        last;
   } entry_type;

   typedef struct {
      logic [1:0]  kind;
      logic [1:0]  var_index;
      logic [31:0] value;
      logic        last;
   } result_type;

   typedef logic signed [199:0] wide_type;

   localparam wide_type SAT_HIGH = 200'sh7FFF_FFFF;
   localparam wide_type SAT_LOW  = -200'sh8000_0000;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   cls_req_if req_bus();
   cls_rsp_if rsp_bus();

   cramer_linear_system_solver_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   entry_type  entry_q[$];
   result_type result_q[$];
   entry_type  offered;

   logic [31:0] system_copy [MAX_SIZE][STORE_COLS];
   int unsigned eq_count;
   int unsigned var_count;
   int unsigned threshold;

   int          queued_n;
   int          accepted_n;
   int          mismatches;
   int          send_gap;
   int          recv_gap;
   int          holdoff_cycles;
   logic        holdoff_start;
   logic        quiet;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.row = '0;
      req_bus.column = '0;
      req_bus.entry_value = '0;
      req_bus.last_entry = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      holdoff_start = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] clamp32(input wide_type v);
      if (v > SAT_HIGH) return 32'h7FFF_FFFF;
      if (v < SAT_LOW) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Exact determinant by summing signed permutation products; when
   // swap_col is below n that column is replaced by the constants.
   function automatic wide_type exact_det(input int unsigned n, input int swap_col);
      wide_type total, prod, term;
      int       digit [4];
      int       k, r, c, inversions;
      bit       distinct;
      total = 0;
      for (k = 0; k < (1 << (2 * n)); k++) begin
         for (r = 0; r < int'(n); r++) digit[r] = (k >> (2 * r)) & 3;
         distinct = 1'b1;
         inversions = 0;
         for (r = 0; r < int'(n); r++) begin
            if (digit[r] >= int'(n)) distinct = 1'b0;
            for (c = r + 1; c < int'(n); c++) begin
               if (digit[r] == digit[c]) distinct = 1'b0;
               if (digit[r] > digit[c]) inversions++;
            end
         end
         if (distinct) begin
            prod = 1;
            for (r = 0; r < int'(n); r++) begin
               term = $signed(digit[r] == swap_col ? system_copy[r][n]
                                                   : system_copy[r][digit[r]]);
               prod = prod * term;
            end
            total = (inversions % 2) ? total - prod : total + prod;
         end
      end
      return total;
   endfunction

   function automatic result_type make_result(input logic [1:0] kind, input int v,
                                              input logic [31:0] value, input logic last);
      result_type res;
      res.kind = kind;
      res.var_index = v[1:0];
      res.value = value;
      res.last = last;
      return res;
   endfunction

   // Stores an accepted entry and, on the last one, predicts the solve.
   task automatic accept_entry(input entry_type e);
      wide_type    det, mag, quotient;
      logic        singular;
      int unsigned n;
      int          v;
      if (e.column <= MAX_SIZE) system_copy[e.row][e.column] = e.value;
      if (e.last) begin
         n = var_count;
         if (eq_count != n || n > MAX_SIZE) begin
            result_q = {result_q, make_result(KIND_NOT_SQUARE, 0, 32'd0, 1'b1)};
         end else begin
            det = exact_det(n, MAX_SIZE + 1);
            mag = det < 0 ? -det : det;
            if (n == 0) mag = mag <<< FRAC_BITS;
            else mag = mag >>> (FRAC_BITS * (n - 1));
            singular = (det == 0) || (mag < wide_type'(threshold));
            result_q = {result_q, make_result(KIND_DETERMINANT, 0,
                                              clamp32(det < 0 ? -mag : mag),
                                              singular || n == 0)};
            if (!singular) begin
               for (v = 0; v < int'(n); v++) begin
                  quotient = (exact_det(n, v) <<< FRAC_BITS) / det;
                  result_q = {result_q, make_result(KIND_SOLUTION, v, clamp32(quotient),
                                                    v + 1 == int'(n))};
               end
            end
         end
         foreach (system_copy[r, c]) system_copy[r][c] = '0;
      end
   endtask

   // Entry driver: presents queued entries, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
         accepted_n <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            accept_entry(offered);
            accepted_n <= accepted_n + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (entry_q.size() > 0) begin
               offered = entry_q.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.row <= offered.row;
               req_bus.column <= offered.column;
               req_bus.entry_value <= offered.value;
               req_bus.last_entry <= offered.last;
               if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 3);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) holdoff_cycles <= 0;
      else if (holdoff_start) holdoff_cycles <= 2500;
      else if (holdoff_cycles > 0) holdoff_cycles <= holdoff_cycles - 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap <= 0;
      end else if (holdoff_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         rsp_bus.ready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 3);
      end
   end

   // Result monitor: each transfer is matched with the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (result_q.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("%0t: unexpected result kind %0d var %0d value %h last %0d",
                        $time, rsp_bus.kind, rsp_bus.var_index, rsp_bus.result_value,
                        rsp_bus.last_result);
         end else begin
            want = result_q.pop_front();
            if (rsp_bus.kind !== want.kind || rsp_bus.var_index !== want.var_index ||
                rsp_bus.result_value !== want.value || rsp_bus.last_result !== want.last)
            begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("%0t: result mismatch: expected %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                           $time, want.kind, want.var_index, want.value, want.last,
                           rsp_bus.kind, rsp_bus.var_index, rsp_bus.result_value,
                           rsp_bus.last_result);
            end
         end
      end
   end

   task automatic push_entry(input int row, input int column, input logic [31:0] value,
                             input bit last);
      entry_type e;
      e.row = row[1:0];
      e.column = column[2:0];
      e.value = value;
      e.last = last;
      entry_q = {entry_q, e};
      queued_n++;
   endtask

   task automatic wait_drained();
      while (accepted_n != queued_n || result_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input int unsigned data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data[15:0];
      case (index)
         CSR_EQUATION_COUNT:     eq_count = data & 7;
         CSR_VARIABLE_COUNT:     var_count = data & 7;
         CSR_SINGULAR_THRESHOLD: threshold = data & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned m, input int unsigned n,
                            input int unsigned thr);
      wait_drained();
      write_reg(CSR_EQUATION_COUNT, m);
      write_reg(CSR_VARIABLE_COUNT, n);
      write_reg(CSR_SINGULAR_THRESHOLD, thr);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 6))
         0: return 32'($signed($urandom_range(0, 8)) - 4) << FRAC_BITS;
         1: return $urandom;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000);
         5: return 32'd0;
         default: return 32'($signed($urandom_range(0, 64)) - 32) << FRAC_BITS;
      endcase
   endfunction

   // A complete system in random column order plus stray entries, or noise.
   task automatic push_system(input int unsigned n);
      int r, c, k, order [5];
      if ($urandom_range(0, 7) != 0) begin
         for (r = 0; r < int'(n); r++) begin
            for (c = 0; c <= int'(n); c++) order[c] = c;
            for (c = int'(n); c > 0; c--) begin
               k = $urandom_range(0, c);
               {order[c], order[k]} = {order[k], order[c]};
            end
            for (c = 0; c <= int'(n); c++) push_entry(r, order[c], random_value(), 0);
            if ($urandom_range(0, 3) == 0)
               push_entry($urandom_range(0, 3), $urandom_range(n + 1, 7), $urandom, 0);
         end
         push_entry($urandom_range(0, 3), $urandom_range(0, 7), random_value(), 1);
      end else begin
         repeat ($urandom_range(1, 4))
            push_entry($urandom_range(0, 3), $urandom_range(0, 7), $urandom,
                       $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      int unsigned m, n, thr;
      int          phase, start_n;
      bit          paused;
      mismatches = 0;
      queued_n = 0;
      quiet = 1'b0;
      paused = 1'b0;
      eq_count = 0;
      var_count = 0;
      threshold = 1;
      foreach (system_copy[r, c]) system_copy[r][c] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty system under reset settings, including an ignored column.
      push_entry(3, 7, 32'h8000_0000, 1);
      push_entry(0, 0, 32'h7FFF_FFFF, 1);
      configure(2, 3, 65535);
      push_entry(1, 2, 5, 0);
      push_entry(2, 4, 32'hFFFF_FFFF, 1);
      configure(5, 5, 1);
      push_entry(0, 5, 1, 1);
      configure(1, 1, 0);
      push_entry(0, 0, 0, 1);
      push_entry(0, 0, 32'h8000_0000, 0);
      push_entry(0, 1, 32'h7FFF_FFFF, 1);
      push_entry(0, 0, 1, 0);
      push_entry(0, 1, 32'h8000_0000, 1);
      configure(2, 2, 65535);
      push_entry(0, 0, 32'h1_0000, 0);
      push_entry(1, 1, 32'h1_0000, 0);
      push_entry(0, 2, 32'h3_0000, 0);
      push_entry(1, 2, 32'hFFFE_0000, 1);
      push_entry(0, 0, 32'h7FFF_FFFF, 0);
      push_entry(1, 1, 32'h7FFF_FFFF, 0);
      push_entry(0, 1, 32'h8000_0000, 0);
      push_entry(1, 0, 32'h8000_0000, 0);
      push_entry(0, 2, 32'h7FFF_FFFF, 0);
      push_entry(1, 2, 32'h8000_0000, 1);

      for (phase = 0; phase < 9; phase++) begin
         n = $urandom_range(0, 4);
         m = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : n;
         case (phase)
            0: thr = 0;
            1: thr = 65535;
            2: begin m = 4; n = 4; thr = 1; end
            default: thr = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4);
         endcase
         configure(m, n, thr[15:0]);
         if (phase == 8) quiet = 1'b1;
         if (phase == 2) begin
            @(posedge clock);
            holdoff_start <= 1'b1;
            @(posedge clock);
            holdoff_start <= 1'b0;
         end
         start_n = queued_n;
         while (queued_n - start_n < 22) begin
            push_system(n);
            // Once per run the sender waits for every pending result.
            if (phase == 3 && !paused) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      wait_drained();
      if (mismatches == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/cls_pkg.sv
rtl/core/cls_req_if.sv
rtl/core/cls_rsp_if.sv
rtl/core/cls_divider.sv
rtl/core/cramer_linear_system_solver_unit.sv
dv/tb_top.sv
